### rtl/tcsm_pkg.sv
// ----------------------------------------------------------------------------
// tcsm_pkg
// Types and constants shared by the triple coincidence single matcher.
// ----------------------------------------------------------------------------
package tcsm_pkg;

  localparam int unsigned TimeW    = 48;
  localparam int unsigned TagW     = 32;
  localparam int unsigned GroupW   = 32;
  localparam int unsigned WindowW  = 32;
  localparam int unsigned LimitW   = 6;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 32;
  // doubled-scale compare width: sum of two times plus a guard bit
  localparam int unsigned Mid2W    = TimeW + 2;

  localparam logic [LimitW-1:0] LimitReset = 6'd50;

  localparam logic CmdSingle = 1'b0;
  localparam logic CmdCoinc  = 1'b1;

  localparam logic [CfgIdxW-1:0] CfgWindow = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgLimit  = 2'd1;

  typedef struct packed {
    logic              cmd;
    logic [TimeW-1:0]  time_first;
    logic [TimeW-1:0]  time_second;
    logic [TagW-1:0]   single_tag;
  } in_item_t;

  typedef struct packed {
    logic              accepted;
    logic [TimeW-1:0]  match_time;
    logic [TagW-1:0]   match_tag;
    logic [GroupW-1:0] group_number;
    logic              is_last;
  } out_item_t;

  typedef struct packed {
    logic [TimeW-1:0] stime;
    logic [TagW-1:0]  stag;
  } entry_t;

  typedef struct packed {
    logic match;
    logic expired;
  } class_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_e;

endpackage

### rtl/tcsm_store.sv
// ----------------------------------------------------------------------------
// tcsm_store
// Single store memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module tcsm_store #(
  parameter int unsigned STORE_DEPTH = 64,
  parameter int unsigned PW          = 6
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [PW-1:0]    waddr_i,
  input  tcsm_pkg::entry_t wdata_i,
  input  logic             re_i,
  input  logic [PW-1:0]    raddr_i,
  output tcsm_pkg::entry_t rdata_o
);
  import tcsm_pkg::*;

  entry_t mem_q [STORE_DEPTH];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/tcsm_classify.sv
// ----------------------------------------------------------------------------
// tcsm_classify
// Sorts one stored single against the coincidence midpoint: match, expired
// or keep. Everything runs at doubled scale.
// ----------------------------------------------------------------------------
module tcsm_classify (
  input  logic [tcsm_pkg::TimeW-1:0]   stime_i,
  input  logic [tcsm_pkg::Mid2W-1:0]   mid2_i,
  input  logic [tcsm_pkg::WindowW-1:0] window_i,
  output tcsm_pkg::class_t             class_o
);
  import tcsm_pkg::*;

  logic [Mid2W-1:0] s2;
  logic [Mid2W-1:0] win2;
  logic [Mid2W-1:0] gap;
  logic             s_gt;

  always_comb begin
    s2      = {1'b0, stime_i, 1'b0};
    win2    = {{(Mid2W - WindowW - 1){1'b0}}, window_i, 1'b0};
    s_gt    = s2 > mid2_i;
    gap     = s_gt ? (s2 - mid2_i) : (mid2_i - s2);
    class_o.match   = gap <= win2;
    // older than midpoint by more than the window
    class_o.expired = !class_o.match && !s_gt;
  end

endmodule

### rtl/triple_coincidence_single_matcher.sv
// ----------------------------------------------------------------------------
// triple_coincidence_single_matcher
// Ordered store of waiting singles matched against coincidence midpoints.
// ----------------------------------------------------------------------------
// Usage:
//   in channel: one request per item; cmd selects a single (appended to the
//   store, oldest entries dropped past the store limit) or a coincidence.
//   A single gives no result. A coincidence scans the store one entry per
//   cycle, unless the out channel stalls it, through the store memory's
//   single read port and writes kept entries back compacted. The next
//   request is taken once the last result is registered. Each match goes
//   out as one result, the last one with is_last set; no match or an empty
//   store gives one rejected result. in_ready_o is low while a coincidence
//   is in progress.
//   out channel: a result register parts the two sides; when the receiver
//   stalls, the scan holds on the next match until the register frees up.
//   cfg channel: always ready; index 0 window_ps, 1 store_limit, others
//   ignored. Write only while idle.
//   Reset clears the store count, group counter and control registers (window 0,
//   limit 50); the store memory itself needs no clearing pass.
// ----------------------------------------------------------------------------
module triple_coincidence_single_matcher #(
  parameter int unsigned STORE_DEPTH = 64
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  tcsm_pkg::in_item_t                 in_data_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output tcsm_pkg::out_item_t                out_data_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [tcsm_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  logic [tcsm_pkg::CfgDataW-1:0]      cfg_data_i
);
  import tcsm_pkg::*;

  localparam int unsigned PW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(STORE_DEPTH + 1);
  localparam int unsigned HPad = CW + 1 - PW;
  localparam int unsigned LW = 7;
  localparam logic [LW-1:0] MaxLim = LW'(STORE_DEPTH - 1);
  localparam logic [CW:0]   DepthW = (CW + 1)'(STORE_DEPTH);

  function automatic logic [PW-1:0] wrap(input logic [CW:0] sum);
    logic [CW:0] r;
    r = (sum >= DepthW) ? (sum - DepthW) : sum;
    return r[PW-1:0];
  endfunction

  state_e              state_q, state_d;
  logic [WindowW-1:0]  window_q;
  logic [LimitW-1:0]   limit_q;
  logic [PW-1:0]       head_q, head_d;
  logic [CW-1:0]       count_q, count_d;
  logic [GroupW-1:0]   group_q, group_d;
  logic [CW-1:0]       rd_idx_q, rd_idx_d;
  logic [CW-1:0]       keep_q, keep_d;
  logic                pend_q, pend_d;
  logic                hold_v_q, hold_v_d;
  entry_t              hold_q, hold_d;
  logic [Mid2W-1:0]    mid2_q, mid2_d;
  logic                out_valid_q, out_valid_d;
  out_item_t           out_q, out_d;

  logic                we;
  logic [PW-1:0]       waddr;
  entry_t              wdata;
  logic                re;
  logic [PW-1:0]       raddr;
  entry_t              rdata;
  class_t              cls;

  logic [LW-1:0]       lim7;
  logic [CW-1:0]       lim;
  logic                over;
  logic [PW-1:0]       head_s;
  logic [CW-1:0]       cnt_s;
  logic                slot_free;
  logic                stall;
  logic                adv;

  tcsm_store #(
    .STORE_DEPTH(STORE_DEPTH),
    .PW         (PW)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .re_i   (re),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  tcsm_classify u_classify (
    .stime_i (rdata.stime),
    .mid2_i  (mid2_q),
    .window_i(window_q),
    .class_o (cls)
  );

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // drop-oldest bookkeeping for a single arrival
  always_comb begin
    lim7   = ({1'b0, limit_q} > MaxLim) ? MaxLim : {1'b0, limit_q};
    lim    = lim7[CW-1:0];
    over   = count_q > lim;
    head_s = over ? wrap({{HPad{1'b0}}, head_q} + {1'b0, count_q - lim}) : head_q;
    cnt_s  = over ? lim : count_q;
  end

  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    count_d     = count_q;
    group_d     = group_q;
    rd_idx_d    = rd_idx_q;
    keep_d      = keep_q;
    pend_d      = pend_q;
    hold_v_d    = hold_v_q;
    hold_d      = hold_q;
    mid2_d      = mid2_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    we          = 1'b0;
    waddr       = wrap({{HPad{1'b0}}, head_q} + {1'b0, keep_q});
    wdata       = rdata;
    re          = 1'b0;
    raddr       = wrap({{HPad{1'b0}}, head_q} + {1'b0, rd_idx_q});
    slot_free   = !out_valid_q || out_ready_i;
    stall       = 1'b0;
    adv         = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (in_data_i.cmd == CmdSingle) begin
            we          = 1'b1;
            waddr       = wrap({{HPad{1'b0}}, head_s} + {1'b0, cnt_s});
            wdata.stime = in_data_i.time_first;
            wdata.stag  = in_data_i.single_tag;
            head_d      = head_s;
            count_d     = cnt_s + 1'b1;
          end else begin
            mid2_d   = {2'b00, in_data_i.time_first} + {2'b00, in_data_i.time_second};
            rd_idx_d = '0;
            keep_d   = '0;
            pend_d   = 1'b0;
            hold_v_d = 1'b0;
            state_d  = (count_q == '0) ? ST_FINISH : ST_SCAN;
          end
        end
      end

      ST_SCAN: begin
        if (pend_q) begin
          // a new match has to push the held one out first
          stall = cls.match && hold_v_q && !slot_free;
          if (!stall) begin
            if (cls.match) begin
              if (hold_v_q) begin
                out_valid_d        = 1'b1;
                out_d.accepted     = 1'b1;
                out_d.match_time   = hold_q.stime;
                out_d.match_tag    = hold_q.stag;
                out_d.group_number = group_q;
                out_d.is_last      = 1'b0;
              end
              hold_d   = rdata;
              hold_v_d = 1'b1;
            end else if (!cls.expired) begin
              we     = 1'b1;
              keep_d = keep_q + 1'b1;
            end
          end
        end
        adv = !pend_q || !stall;
        if (adv) begin
          if (rd_idx_q < count_q) begin
            re       = 1'b1;
            rd_idx_d = rd_idx_q + 1'b1;
            pend_d   = 1'b1;
          end else begin
            pend_d  = 1'b0;
            state_d = ST_FINISH;
          end
        end
      end

      ST_FINISH: begin
        if (slot_free) begin
          out_valid_d        = 1'b1;
          out_d.accepted     = hold_v_q;
          out_d.match_time   = hold_v_q ? hold_q.stime : '0;
          out_d.match_tag    = hold_v_q ? hold_q.stag : '0;
          out_d.group_number = group_q;
          out_d.is_last      = 1'b1;
          count_d            = keep_q;
          if (hold_v_q) begin
            group_d = group_q + 1'b1;
          end
          hold_v_d = 1'b0;
          state_d  = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      head_q      <= '0;
      count_q     <= '0;
      group_q     <= '0;
      rd_idx_q    <= '0;
      keep_q      <= '0;
      pend_q      <= 1'b0;
      hold_v_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      count_q     <= count_d;
      group_q     <= group_d;
      rd_idx_q    <= rd_idx_d;
      keep_q      <= keep_d;
      pend_q      <= pend_d;
      hold_v_q    <= hold_v_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hold_q <= hold_d;
    mid2_q <= mid2_d;
    out_q  <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= '0;
      limit_q  <= LimitReset;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgWindow: window_q <= cfg_data_i[WindowW-1:0];
        CfgLimit:  limit_q  <= cfg_data_i[LimitW-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule
